// File: src/biquad_pre_emphasis_q31_macros.svh
// Assertion macros for the checker file of the filter block.
`ifndef BIQUAD_PRE_EMPHASIS_Q31_MACROS_SVH
`define BIQUAD_PRE_EMPHASIS_Q31_MACROS_SVH

// Checked on every clock edge outside reset.
`define BPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/biqpe_pkg.sv
// Types, constants and saturating Q31 arithmetic for the biquad filter block.
package biqpe_pkg;

  typedef logic signed [31:0] q31_t;

  localparam q31_t Q31_MAX = 32'sh7FFF_FFFF;
  localparam q31_t Q31_MIN = 32'sh8000_0000;

  localparam q31_t COEF_B0_RST = 32'sd999576523;
  localparam q31_t COEF_B1_RST = -32'sd1665830811;
  localparam q31_t COEF_B2_RST = 32'sd733657884;
  localparam q31_t COEF_A1_RST = -32'sd818082248;
  localparam q31_t COEF_A2_RST = 32'sd348614933;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_B0 = 3'd0,
    CFG_COEF_B1 = 3'd1,
    CFG_COEF_B2 = 3'd2,
    CFG_COEF_A1 = 3'd3,
    CFG_COEF_A2 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    q31_t b0;
    q31_t b1;
    q31_t b2;
    q31_t a1;
    q31_t a2;
  } biqpe_coef_t;

  typedef struct packed {
    q31_t x1;
    q31_t x2;
    q31_t y1;
    q31_t y2;
  } biqpe_hist_t;

  // Clamp a 33-bit two's complement value to the Q31 range.
  function automatic q31_t sat33(logic [32:0] v);
    q31_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? Q31_MIN : Q31_MAX;
    end else begin
      r = signed'(v[31:0]);
    end
    return r;
  endfunction

  // Fractional multiply: the product shifted right by 31 rounds toward minus
  // infinity, which the arithmetic part-select gives directly.
  function automatic q31_t q31_mul(q31_t a, q31_t b);
    logic signed [63:0] p;
    p = a * b;
    return sat33(p[63:31]);
  endfunction

  function automatic q31_t q31_add(q31_t a, q31_t b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic q31_t q31_sub(q31_t a, q31_t b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  function automatic q31_t q31_shl2(q31_t a);
    q31_t r;
    if (a[31:29] != {3{a[31]}}) begin
      r = a[31] ? Q31_MIN : Q31_MAX;
    end else begin
      r = signed'({a[29:0], 2'b00});
    end
    return r;
  endfunction

endpackage

// File: src/biqpe_coef_regs.sv
// Coefficient register file written through the configuration port.
module biqpe_coef_regs
  import biqpe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  output biqpe_coef_t          coef_o
);

  biqpe_coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= COEF_B0_RST;
      coef_q.b1 <= COEF_B1_RST;
      coef_q.b2 <= COEF_B2_RST;
      coef_q.a1 <= COEF_A1_RST;
      coef_q.a2 <= COEF_A2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_B0: coef_q.b0 <= signed'(cfg_wdata_i);
        CFG_COEF_B1: coef_q.b1 <= signed'(cfg_wdata_i);
        CFG_COEF_B2: coef_q.b2 <= signed'(cfg_wdata_i);
        CFG_COEF_A1: coef_q.a1 <= signed'(cfg_wdata_i);
        CFG_COEF_A2: coef_q.a2 <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

// File: src/biqpe_core.sv
// Filter arithmetic: five fractional products, saturating sums and output shift.
module biqpe_core
  import biqpe_pkg::*;
(
  input  biqpe_coef_t coef_i,
  input  biqpe_hist_t hist_i,
  input  q31_t        sample_i,
  input  logic        block_start_i,
  output q31_t        sample_o,
  output biqpe_hist_t hist_next_o
);

  biqpe_hist_t hist_eff;
  q31_t        ff;
  q31_t        fb;
  q31_t        acc;
  q31_t        y;

  // A block start makes the sample see an all-zero history.
  assign hist_eff = block_start_i ? '0 : hist_i;

  always_comb begin
    ff  = q31_add(q31_add(q31_mul(coef_i.b0, sample_i), q31_mul(coef_i.b1, hist_eff.x1)),
                  q31_mul(coef_i.b2, hist_eff.x2));
    fb  = q31_add(q31_mul(coef_i.a1, hist_eff.y1), q31_mul(coef_i.a2, hist_eff.y2));
    acc = q31_sub(ff, fb);
    y   = q31_shl2(acc);
  end

  assign sample_o       = y;
  assign hist_next_o.x1 = sample_i;
  assign hist_next_o.x2 = hist_eff.x1;
  assign hist_next_o.y1 = y;
  assign hist_next_o.y2 = hist_eff.y1;

endmodule

// File: src/biquad_pre_emphasis_q31.sv
// Top level of the direct form I biquad filter on Q31 samples.
//
// Usage:
//   Input channel: in_valid_i, sample_in_i, block_start_i; the block drives
//   in_stall_o. A transaction happens at an edge with valid high, stall low.
//   Output channel: out_valid_o, sample_out_o; the receiver drives out_stall_i.
//   Each input transaction yields exactly one output transaction, in order.
//   An accepted sample goes from the input register to the result register,
//   which presents it on the output. Throughput: one sample per cycle unless
//   the receiver stalls. The figure is set by the output feedback loop, which
//   runs combinationally from the history registers through the five
//   multipliers and the saturating add chain back into the history.
//   When the receiver stalls, the result register holds and the input register
//   keeps one more sample; then in_stall_o rises until the output moves.
//   block_start_i clears all filter history before its sample is used.
//   Reset empties both registers, zeroes the history and reloads the default
//   coefficients. The user writes coefficients through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i only while no sample is in flight; the block does not enforce it.
module biquad_pre_emphasis_q31
  import biqpe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   sample_in_i,
  input  logic                 block_start_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   sample_out_o
);

  biqpe_coef_t coef;
  biqpe_hist_t hist_q;
  biqpe_hist_t hist_d;

  logic in_vld_q;
  q31_t x_q;
  logic start_q;
  logic out_vld_q;
  q31_t y_q;
  q31_t y_d;
  logic advance;
  logic in_take;

  biqpe_coef_regs u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  biqpe_core u_core (
    .coef_i        (coef),
    .hist_i        (hist_q),
    .sample_i      (x_q),
    .block_start_i (start_q),
    .sample_o      (y_d),
    .hist_next_o   (hist_d)
  );

  // The input register moves into the result register whenever that one is
  // empty or being drained in the same cycle.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      hist_q    <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        hist_q    <= hist_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q     <= sample_in_i;
      start_q <= block_start_i;
    end
    if (advance) begin
      y_q <= y_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = y_q;

endmodule

// File: src/biqpe_checker.sv
// Port-level assertions for the biquad filter, bound to its top level.
`include "biquad_pre_emphasis_q31_macros.svh"

module biqpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] sample_out_o
);

  // A stalled result stays on the port unchanged.
  `BPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o), "stalled output changed")

  // The input side only stalls while a result is held back by the receiver.
  `BPQ_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")

  // No result is shown while the block is held in reset.
  `BPQ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

  // A result that appears on an empty output came from an earlier input transaction.
  `BPQ_ASSERT(a_out_origin, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "output without input")

endmodule

bind biquad_pre_emphasis_q31 biqpe_checker u_biqpe_checker (.*);

// File: test/tb_biquad_pre_emphasis_q31.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Q31 direct form I biquad filter block.
module tb_biquad_pre_emphasis_q31;
  import biqpe_pkg::*;

  localparam int ITEMS_PER_PHASE  = 210;
  localparam int NUM_PHASES       = 8;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES    = 4;

  localparam biqpe_coef_t COEFS_RST =
    '{COEF_B0_RST, COEF_B1_RST, COEF_B2_RST, COEF_A1_RST, COEF_A2_RST};
  localparam biqpe_coef_t COEFS_MIN_B0  = '{Q31_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam biqpe_coef_t COEFS_RAILS   = '{Q31_MAX, Q31_MAX, Q31_MAX, Q31_MIN, Q31_MIN};
  localparam biqpe_coef_t COEFS_FB_ONLY = '{32'sd0, 32'sd0, 32'sd0, Q31_MIN, Q31_MIN};
  localparam biqpe_coef_t COEFS_B0_A1   = '{Q31_MAX, 32'sd0, 32'sd0, Q31_MIN, 32'sd0};

  typedef struct packed {
    logic        load;
    biqpe_coef_t coefs;
    q31_t        x;
    logic        start;
    logic        known;
    q31_t        want;
  } stim_row_t;

  // Columns: load coefficients first, coefficients, sample, block start,
  // result known by hand, that result.
  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{1'b0, COEFS_RST,     32'sd0,         1'b1, 1'b1, 32'sd0},
    '{1'b0, COEFS_RST,     Q31_MIN,        1'b1, 1'b1, Q31_MIN},
    '{1'b0, COEFS_RST,     Q31_MAX,        1'b1, 1'b1, Q31_MAX},
    '{1'b0, COEFS_RST,     -32'sd1,        1'b1, 1'b1, -32'sd4},
    '{1'b0, COEFS_RST,     32'sd1,         1'b1, 1'b1, 32'sd0},
    '{1'b0, COEFS_RST,     32'sh4000_0000, 1'b0, 1'b0, 32'sd0},
    '{1'b0, COEFS_RST,     32'sh7FFF_0000, 1'b0, 1'b0, 32'sd0},
    '{1'b0, COEFS_RST,     Q31_MIN,        1'b0, 1'b0, 32'sd0},
    '{1'b0, COEFS_RST,     32'sd12345,     1'b0, 1'b0, 32'sd0},
    '{1'b0, COEFS_RST,     32'sd0,         1'b1, 1'b1, 32'sd0},
    '{1'b1, COEFS_MIN_B0,  Q31_MIN,        1'b1, 1'b1, Q31_MAX},
    '{1'b0, COEFS_MIN_B0,  Q31_MAX,        1'b1, 1'b1, Q31_MIN},
    '{1'b0, COEFS_MIN_B0,  Q31_MIN,        1'b0, 1'b1, Q31_MAX},
    '{1'b1, COEFS_RAILS,   Q31_MAX,        1'b1, 1'b1, Q31_MAX},
    '{1'b0, COEFS_RAILS,   Q31_MAX,        1'b0, 1'b0, 32'sd0},
    '{1'b0, COEFS_RAILS,   Q31_MIN,        1'b0, 1'b0, 32'sd0},
    '{1'b0, COEFS_RAILS,   32'sd0,         1'b0, 1'b0, 32'sd0},
    '{1'b1, COEFS_FB_ONLY, Q31_MAX,        1'b1, 1'b1, 32'sd0},
    '{1'b1, COEFS_B0_A1,   Q31_MAX,        1'b1, 1'b1, Q31_MAX},
    '{1'b0, COEFS_B0_A1,   32'sd0,         1'b0, 1'b0, 32'sd0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [31:0]   sample_in_i;
  logic                 block_start_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [31:0]   sample_out_o;

  biqpe_coef_t shadow_coefs;
  biqpe_hist_t shadow_hist;
  q31_t        pending_outputs[$];
  int          failures;
  int          idle_pct;
  int          stall_pct;
  int          holds_requested;
  int          holds_served;

  biquad_pre_emphasis_q31 dut (.*);

  function automatic q31_t clamp_q31(longint v);
    if (v > longint'(Q31_MAX)) return Q31_MAX;
    if (v < longint'(Q31_MIN)) return Q31_MIN;
    return q31_t'(v);
  endfunction

  // The arithmetic shift of the 64-bit product floors toward minus infinity.
  function automatic q31_t frac_mul(q31_t a, q31_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_q31(p >>> 31);
  endfunction

  function automatic q31_t sat_add(q31_t a, q31_t b);
    return clamp_q31(longint'(a) + longint'(b));
  endfunction

  function automatic q31_t filter_step(q31_t x, logic start);
    q31_t ff;
    q31_t fb;
    q31_t acc;
    q31_t y;
    if (start) begin
      shadow_hist = '0;
    end
    ff = sat_add(sat_add(frac_mul(shadow_coefs.b0, x),
                         frac_mul(shadow_coefs.b1, shadow_hist.x1)),
                 frac_mul(shadow_coefs.b2, shadow_hist.x2));
    fb = sat_add(frac_mul(shadow_coefs.a1, shadow_hist.y1),
                 frac_mul(shadow_coefs.a2, shadow_hist.y2));
    acc = clamp_q31(longint'(ff) - longint'(fb));
    y = clamp_q31(longint'(acc) * 4);
    shadow_hist.x2 = shadow_hist.x1;
    shadow_hist.x1 = x;
    shadow_hist.y2 = shadow_hist.y1;
    shadow_hist.y1 = y;
    return y;
  endfunction

  function automatic q31_t random_sample();
    case ($urandom_range(9))
      0: return Q31_MIN;
      1: return Q31_MAX;
      2, 3, 4: return q31_t'($urandom);
      5, 6, 7: return q31_t'($urandom) >>> $urandom_range(24, 4);
      8: return q31_t'($urandom_range(2)) - 32'sd1;
      default: begin
        if ($urandom_range(1)) return Q31_MAX - q31_t'($urandom_range(255));
        return Q31_MIN + q31_t'($urandom_range(255));
      end
    endcase
  endfunction

  task automatic send_sample(q31_t x, logic start, logic known, q31_t want);
    q31_t predicted;
    in_valid_i    <= 1'b1;
    sample_in_i   <= x;
    block_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    predicted = filter_step(x, start);
    pending_outputs.push_back(known ? want : predicted);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, q31_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (cfg_reg_e'(idx))
      CFG_COEF_B0: shadow_coefs.b0 = data;
      CFG_COEF_B1: shadow_coefs.b1 = data;
      CFG_COEF_B2: shadow_coefs.b2 = data;
      CFG_COEF_A1: shadow_coefs.a1 = data;
      CFG_COEF_A2: shadow_coefs.a2 = data;
      default: ;
    endcase
  endtask

  // Writes to the unused indexes go last, so any aliasing onto a real
  // coefficient would corrupt the set just loaded.
  task automatic load_coefs(biqpe_coef_t c);
    drain_outputs();
    write_reg(CFG_COEF_B0, c.b0);
    write_reg(CFG_COEF_B1, c.b1);
    write_reg(CFG_COEF_B2, c.b2);
    write_reg(CFG_COEF_A1, c.a1);
    write_reg(CFG_COEF_A2, c.a2);
    for (int i = int'(CFG_COEF_A2) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), q31_t'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("biquad_pre_emphasis_q31 regression: fail");
    $finish;
  end

  // Receiver side: random stalls, plus one long hold-off on request so that
  // the block backs up and stalls its input.
  initial begin
    out_stall_i <= 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_requested) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    q31_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        $error("sample_out: no transaction expected, got %0d", sample_out_o);
        failures++;
      end else begin
        want = pending_outputs.pop_front();
        if (sample_out_o !== want) begin
          $error("sample_out: expected %0d, got %0d", want, sample_out_o);
          failures++;
        end
      end
    end
  end

  initial begin
    biqpe_coef_t c;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    sample_in_i   <= '0;
    block_start_i <= 1'b0;
    failures        = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    holds_requested = 0;
    shadow_coefs    = COEFS_RST;
    shadow_hist     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].load) begin
        load_coefs(DIRECTED_ROWS[i].coefs);
      end
      send_sample(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].start,
                  DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: c = '{Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX, Q31_MAX};
        2: c = '{Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN, Q31_MIN};
        3, 6: c = {$urandom, $urandom, $urandom, $urandom, $urandom};
        4: c = '{q31_t'($urandom) >>> 2, q31_t'($urandom) >>> 2, q31_t'($urandom) >>> 2,
                 q31_t'($urandom) >>> 2, q31_t'($urandom) >>> 2};
        5: c = '{Q31_MAX, Q31_MIN, Q31_MAX, Q31_MIN, Q31_MAX};
        default: c = COEFS_RST;
      endcase
      load_coefs(c);
      case (phase % 4)
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        3: begin idle_pct = 30; stall_pct = 30; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (phase == 4) begin
        holds_requested++;
      end
      // Short blocks: a block start now and then resets the filter history.
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_sample(random_sample(), ($urandom_range(31) == 0), 1'b0, 32'sd0);
      end
    end

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("biquad_pre_emphasis_q31 regression: pass");
    end else begin
      $display("biquad_pre_emphasis_q31 regression: fail");
    end
    $finish;
  end

endmodule

// File: biquad_pre_emphasis_q31.f
+incdir+src
src/biqpe_pkg.sv
src/biqpe_coef_regs.sv
src/biqpe_core.sv
src/biquad_pre_emphasis_q31.sv
src/biqpe_checker.sv
test/tb_biquad_pre_emphasis_q31.sv
